/* rtl/srb_pkg.sv */
// Shared types and command codes for the serial receive and transmit ring buffers.
package srb_pkg;

    localparam logic [1:0] CMD_LINE_RX   = 2'd0;
    localparam logic [1:0] CMD_CPU_READ  = 2'd1;
    localparam logic [1:0] CMD_CPU_WRITE = 2'd2;
    localparam logic [1:0] CMD_NONE      = 2'd3;

    localparam logic [7:0] DATA_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0] cmd;
        logic       tx_done;
        logic [7:0] data_byte;
        logic       tx_idle;
    } item_t;

    typedef struct packed {
        logic       line_send;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       write_refused;
        logic       rx_overrun;
        logic       rx_available;
        logic       tx_space;
    } result_t;

    // Control carried from the memory read cycle to the result register
    typedef struct packed {
        logic       send_direct;
        logic       send_stored;
        logic [7:0] direct_byte;
        logic       pop;
        logic       refused;
        logic       overrun;
        logic       rx_available;
        logic       tx_space;
    } stage_t;

endpackage

/* rtl/srb_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/serial_rx_tx_ring_buffers.sv */
// Serial port buffering: receive ring and transmit ring of DEPTH bytes, each holding DEPTH-1.
// Each result passes the RAM read stage (s1 register) and then the result register after its item is transferred.
// Throughput: one item per cycle while results are taken; each item does at most one read or one write of one ring RAM.
// Reset clears the ring pointers (both rings empty) and sets the data mask to all ones;
// the ring RAMs are not cleared and need no clearing pass.
module serial_rx_tx_ring_buffers
    import srb_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int PW = $clog2(DEPTH);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == LAST) ? '0 : p + PW'(1);
    endfunction

    logic [7:0]    data_mask_reg;
    logic [PW-1:0] rx_head_reg, rx_head_next;
    logic [PW-1:0] rx_tail_reg, rx_tail_next;
    logic [PW-1:0] tx_head_reg, tx_head_next;
    logic [PW-1:0] tx_tail_reg, tx_tail_next;
    logic          s1_valid_reg, s1_valid_next;
    stage_t        s1_reg, s1_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          item_fire;
    logic          s1_adv;
    logic [PW-1:0] rx_head_inc, rx_tail_inc, tx_head_inc, tx_tail_inc;
    logic          rx_empty, rx_full, tx_empty, tx_full;

    logic          rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [PW-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
    logic [7:0]    rx_wr_data, tx_wr_data;
    logic [7:0]    rx_rd_data, tx_rd_data;

    assign cfg_ready    = 1'b1;
    assign s1_adv       = !out_valid_reg || result_ready;
    assign item_ready   = !s1_valid_reg || s1_adv;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign rx_head_inc = ring_next(rx_head_reg);
    assign rx_tail_inc = ring_next(rx_tail_reg);
    assign tx_head_inc = ring_next(tx_head_reg);
    assign tx_tail_inc = ring_next(tx_tail_reg);
    assign rx_empty    = rx_head_reg == rx_tail_reg;
    assign rx_full     = rx_tail_inc == rx_head_reg;
    assign tx_empty    = tx_head_reg == tx_tail_reg;
    assign tx_full     = tx_tail_inc == tx_head_reg;

    // Decode the item against current pointers; RAM accesses start on the transfer
    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        s1_next      = s1_reg;
        rx_wr_en     = 1'b0;
        rx_wr_addr   = rx_tail_inc;
        rx_wr_data   = item.data_byte & data_mask_reg;
        rx_rd_en     = 1'b0;
        rx_rd_addr   = rx_head_inc;
        tx_wr_en     = 1'b0;
        tx_wr_addr   = tx_tail_reg;
        tx_wr_data   = item.data_byte;
        tx_rd_en     = 1'b0;
        tx_rd_addr   = tx_head_reg;

        if (item_fire)
        begin
            s1_next = '0;
            if (item.tx_done)
            begin
                if (item.tx_idle && !tx_empty)
                begin
                    tx_rd_en            = 1'b1;
                    tx_head_next        = tx_head_inc;
                    s1_next.send_stored = 1'b1;
                end
            end
            else
            begin
                case (item.cmd)
                    CMD_LINE_RX:
                    begin
                        if (!rx_full)
                        begin
                            rx_wr_en     = 1'b1;
                            rx_tail_next = rx_tail_inc;
                        end
                        else
                        begin
                            s1_next.overrun = 1'b1;
                        end
                    end
                    CMD_CPU_READ:
                    begin
                        if (!rx_empty)
                        begin
                            rx_rd_en     = 1'b1;
                            rx_head_next = rx_head_inc;
                            s1_next.pop  = 1'b1;
                        end
                    end
                    CMD_CPU_WRITE:
                    begin
                        if (tx_full)
                        begin
                            s1_next.refused = 1'b1;
                        end
                        else if (tx_empty && item.tx_idle)
                        begin
                            s1_next.send_direct = 1'b1;
                            s1_next.direct_byte = item.data_byte;
                        end
                        else
                        begin
                            tx_wr_en     = 1'b1;
                            tx_tail_next = tx_tail_inc;
                        end
                    end
                    default:
                    begin
                        // CMD_NONE: no change
                    end
                endcase
            end
            s1_next.rx_available = rx_head_next != rx_tail_next;
            s1_next.tx_space     = ring_next(tx_tail_next) != tx_head_next;
        end
    end

    // Result register: merge RAM read data with the decoded flags
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (s1_valid_reg && s1_adv)
        begin
            s1_valid_next          = 1'b0;
            out_valid_next         = 1'b1;
            out_next.line_send     = s1_reg.send_direct || s1_reg.send_stored;
            out_next.line_byte     = s1_reg.send_stored ? tx_rd_data : s1_reg.direct_byte;
            out_next.read_valid    = s1_reg.pop;
            out_next.read_byte     = s1_reg.pop ? rx_rd_data : 8'd0;
            out_next.write_refused = s1_reg.refused;
            out_next.rx_overrun    = s1_reg.overrun;
            out_next.rx_available  = s1_reg.rx_available;
            out_next.tx_space      = s1_reg.tx_space;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (item_fire)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mask_reg <= DATA_MASK_RESET;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                data_mask_reg <= cfg_data;
            end
            rx_head_reg   <= rx_head_next;
            rx_tail_reg   <= rx_tail_next;
            tx_head_reg   <= tx_head_next;
            tx_tail_reg   <= tx_tail_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    srb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    srb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    // Read data must hold while the decoded item waits for the result register
    a_rdata_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> $stable(rx_rd_data) && $stable(tx_rd_data))
        else $error("ring RAM read data changed under a stalled item");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rx_head_reg <= LAST && rx_tail_reg <= LAST && tx_head_reg <= LAST
        && tx_tail_reg <= LAST)
        else $error("ring pointer beyond last slot");

    a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rx_overrun |-> result.rx_available)
        else $error("overrun reported on a ring that is not full");

    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.write_refused |-> !result.tx_space)
        else $error("write refused while transmit ring has space");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.line_send && result.read_valid))
        else $error("send and read reported for the same transfer");

endmodule

/* tb/sv/serial_rx_tx_ring_buffers_tb.sv */
// Self-checking testbench for the serial receive/transmit ring buffer pair.
`timescale 1ns / 100ps

module serial_rx_tx_ring_buffers_tb
    import srb_pkg::*;
;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef enum {MIXED, RX_FILL, RX_DRAIN, TX_FILL, TX_DRAIN} traffic_t;

    // Mirrors both rings and the data mask; predicts one result per transfer.
    class ring_pair_scoreboard;
        logic [7:0] data_mask;
        logic [7:0] rx_mem [256];
        logic [7:0] tx_mem [256];
        logic [7:0] rx_rd, rx_wr, tx_rd, tx_wr;
        result_t awaited_results [$];
        int unsigned fails;

        function new();
            data_mask = DATA_MASK_RESET;
            rx_rd = '0;
            rx_wr = '0;
            tx_rd = '0;
            tx_wr = '0;
            fails = 0;
        endfunction

        function void set_mask(logic [7:0] m);
            data_mask = m;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function result_t buffer_event(item_t it);
            result_t r;
            logic [7:0] nxt;
            r = '0;
            if (it.tx_done)
            begin
                if (it.tx_idle && tx_rd != tx_wr)
                begin
                    r.line_send = 1'b1;
                    r.line_byte = tx_mem[tx_rd];
                    tx_rd = tx_rd + 8'd1;
                end
            end
            else
            begin
                case (it.cmd)
                    CMD_LINE_RX:
                    begin
                        // receive ring stores one past the tail
                        nxt = rx_wr + 8'd1;
                        if (nxt != rx_rd)
                        begin
                            rx_mem[nxt] = it.data_byte & data_mask;
                            rx_wr = nxt;
                        end
                        else
                        begin
                            r.rx_overrun = 1'b1;
                        end
                    end
                    CMD_CPU_READ:
                    begin
                        if (rx_rd != rx_wr)
                        begin
                            rx_rd = rx_rd + 8'd1;
                            r.read_valid = 1'b1;
                            r.read_byte = rx_mem[rx_rd];
                        end
                    end
                    CMD_CPU_WRITE:
                    begin
                        nxt = tx_wr + 8'd1;
                        if (nxt == tx_rd)
                        begin
                            r.write_refused = 1'b1;
                        end
                        else if (tx_rd == tx_wr && it.tx_idle)
                        begin
                            // bypass the ring, byte goes out unmasked
                            r.line_send = 1'b1;
                            r.line_byte = it.data_byte;
                        end
                        else
                        begin
                            tx_mem[tx_wr] = it.data_byte;
                            tx_wr = nxt;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            nxt = tx_wr + 8'd1;
            r.rx_available = (rx_rd != rx_wr);
            r.tx_space = (nxt != tx_rd);
            return r;
        endfunction

        function void note_item(item_t it);
            awaited_results.push_back(buffer_event(it));
        endfunction

        function string show(result_t r);
            return $sformatf({"send=%0d byte=%02h rvalid=%0d rbyte=%02h",
                              " refused=%0d overrun=%0d avail=%0d space=%0d"},
                r.line_send, r.line_byte, r.read_valid, r.read_byte,
                r.write_refused, r.rx_overrun, r.rx_available, r.tx_space);
        endfunction

        function void check(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: %s", show(got));
                return;
            end
            want = awaited_results.pop_front();
            if (got.line_send !== want.line_send || got.line_byte !== want.line_byte ||
                got.read_valid !== want.read_valid || got.read_byte !== want.read_byte ||
                got.write_refused !== want.write_refused ||
                got.rx_overrun !== want.rx_overrun ||
                got.rx_available !== want.rx_available || got.tx_space !== want.tx_space)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch at %0t\n  expected %s\n  actual   %s",
                        $realtime, show(want), show(got));
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    item_t      item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;

    ring_pair_scoreboard board;
    bit gaps_on = 1'b1;
    bit hold_request = 1'b0;
    int unsigned quiet_cycles = 0;

    serial_rx_tx_ring_buffers DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= !gaps_on || ($urandom_range(99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            board.check(result);
    end

    // Stop the run when no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (cfg_valid && cfg_ready) ||
            (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input item_t it);
        while (gaps_on && $urandom_range(99) < 21)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        board.note_item(it);
    endtask

    task automatic write_mask(input logic [7:0] m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_mask(m);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic item_t make_item(logic [1:0] cmd, logic done, logic [7:0] data,
                                        logic idle);
        item_t it;
        it.cmd = cmd;
        it.tx_done = done;
        it.data_byte = data;
        it.tx_idle = idle;
        return it;
    endfunction

    function automatic item_t rand_item(traffic_t mode);
        item_t it;
        int unsigned pick;
        it.cmd = 2'($urandom_range(3));
        it.tx_done = ($urandom_range(99) < 10);
        it.data_byte = 8'($urandom);
        it.tx_idle = 1'($urandom_range(1));
        pick = $urandom_range(99);
        case (mode)
            RX_FILL:
            begin
                if (pick < 95)
                begin
                    it.cmd = CMD_LINE_RX;
                    it.tx_done = 1'b0;
                end
            end
            RX_DRAIN:
            begin
                if (pick < 95)
                begin
                    it.cmd = CMD_CPU_READ;
                    it.tx_done = 1'b0;
                end
            end
            TX_FILL:
            begin
                // mostly busy transmitter so writes queue up
                if (pick < 90)
                begin
                    it.cmd = CMD_CPU_WRITE;
                    it.tx_done = 1'b0;
                    it.tx_idle = (pick < 10);
                end
            end
            TX_DRAIN:
            begin
                if (pick < 90)
                begin
                    it.tx_done = 1'b1;
                    it.tx_idle = ($urandom_range(99) < 95);
                end
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    task automatic run_phase(input traffic_t mode, input int unsigned count,
                             input logic [7:0] m);
        int unsigned i;
        wait_drained();
        write_mask(m);
        gaps_on = (mode != TX_FILL);
        if (mode == RX_FILL)
            hold_request = 1'b1;
        for (i = 0; i < count; i++)
            send_item(rand_item(mode));
        item_valid <= 1'b0;
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty rings, data byte extremes, bypass, queued sends, ignored cmd
        send_item(make_item(CMD_CPU_READ, 1'b0, 8'h00, 1'b1));
        send_item(make_item(CMD_NONE, 1'b1, 8'h00, 1'b1));
        send_item(make_item(CMD_NONE, 1'b0, 8'hFF, 1'b1));
        send_item(make_item(CMD_LINE_RX, 1'b0, 8'hFF, 1'b0));
        send_item(make_item(CMD_LINE_RX, 1'b0, 8'h00, 1'b1));
        send_item(make_item(CMD_LINE_RX, 1'b0, 8'hA5, 1'b0));
        send_item(make_item(CMD_CPU_READ, 1'b0, 8'h00, 1'b0));
        send_item(make_item(CMD_CPU_READ, 1'b0, 8'hFF, 1'b1));
        send_item(make_item(CMD_CPU_READ, 1'b0, 8'h00, 1'b0));
        send_item(make_item(CMD_CPU_READ, 1'b0, 8'h00, 1'b1));
        send_item(make_item(CMD_CPU_WRITE, 1'b0, 8'h5A, 1'b1));
        send_item(make_item(CMD_CPU_WRITE, 1'b0, 8'hFF, 1'b0));
        send_item(make_item(CMD_CPU_WRITE, 1'b0, 8'h00, 1'b1));
        send_item(make_item(CMD_CPU_WRITE, 1'b1, 8'h33, 1'b0));
        send_item(make_item(CMD_CPU_WRITE, 1'b1, 8'h33, 1'b1));
        send_item(make_item(CMD_LINE_RX, 1'b1, 8'hC3, 1'b1));
        send_item(make_item(CMD_CPU_READ, 1'b1, 8'h00, 1'b1));
        send_item(make_item(CMD_NONE, 1'b0, 8'h00, 1'b0));
        item_valid <= 1'b0;

        run_phase(MIXED, 100, 8'h00);
        run_phase(RX_FILL, 300, 8'h1F);
        run_phase(RX_DRAIN, 300, 8'h3F);
        run_phase(TX_FILL, 300, 8'hFF);
        run_phase(TX_DRAIN, 320, 8'($urandom));
        run_phase(MIXED, 100, 8'h7F);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/srb_pkg.sv
rtl/srb_ram.sv
rtl/serial_rx_tx_ring_buffers.sv
tb/sv/serial_rx_tx_ring_buffers_tb.sv
